FILE: rtl/core/porf_pkg.sv
// porf_pkg: shared types and constants of the primed overwrite ring fifo
// item structs for both channels, register indexes, reset values
// no dependencies
package porf_pkg;

    localparam int DEPTH_DEF    = 4096;
    localparam int MAX_READ_DEF = 64;

    // width of the configuration registers and of the fill count
    localparam int CFG_W = 13;

    localparam logic [CFG_W-1:0] CAPACITY_RST = 13'd4096;
    localparam logic [CFG_W-1:0] PRIME_RST    = 13'd2048;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_PRIME    = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       write_last;
        logic [6:0] read_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             last;
        logic [CFG_W-1:0] fill_level;
        logic             primed_flag;
        logic [31:0]      underrun_count;
        logic [31:0]      overrun_count;
    } t_out_item;

endpackage

FILE: rtl/core/primed_overwrite_ring_fifo_top.sv
// primed_overwrite_ring_fifo_top: byte ring fifo with overwrite, priming and counters
// a write item gives no result; a read item of length L gives min(L, MAX_READ)
// results (none when L is zero), one per cycle, the first passing the state and
// output registers after the transfer, the rate set by the single ring read port;
// output stalls hold the burst; input is stalled while a burst is being emitted
// synchronous active-low reset clears pointers, fill, flags and counters
// depends on porf_pkg and porf_ram
module primed_overwrite_ring_fifo_top #(
    parameter int DEPTH    = porf_pkg::DEPTH_DEF,
    parameter int MAX_READ = porf_pkg::MAX_READ_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  porf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output porf_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    import porf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int PW = ((AW > CFG_W) ? AW : CFG_W) + 1;

    typedef enum logic {ST_IDLE, ST_BURST} t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CFG_W-1:0] r_count, n_count;
    logic             r_primed, n_primed;
    logic             r_ovf, n_ovf;
    logic [31:0]      r_underruns, n_underruns;
    logic [31:0]      r_overruns, n_overruns;
    logic [CFG_W-1:0] r_cap_raw, n_cap_raw;
    logic [CFG_W-1:0] r_prime, n_prime;
    logic             r_zero, n_zero;
    logic [6:0]       r_left, n_left;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out_item, n_out_item;

    logic [CFG_W-1:0] cap_eff;
    logic [CFG_W-1:0] thr;
    logic [AW-1:0]    wp_inc, rp_inc;
    logic             in_xfer, out_free, cfg_wr, full;
    logic             mem_we;
    logic [7:0]       rd_data;
    logic [6:0]       len;

    // out-of-range capacity folds into 1..DEPTH
    always_comb begin
        if (r_cap_raw == '0) begin
            cap_eff = CFG_W'(1);
        end else if (PW'(r_cap_raw) > PW'(DEPTH)) begin
            cap_eff = CFG_W'(DEPTH);
        end else begin
            cap_eff = r_cap_raw;
        end
    end

    assign thr    = (r_prime < cap_eff) ? r_prime : (cap_eff >> 1);
    assign wp_inc = ((PW'(r_wp) + PW'(1)) == PW'(cap_eff)) ? '0 : AW'(r_wp + AW'(1));
    assign rp_inc = ((PW'(r_rp) + PW'(1)) == PW'(cap_eff)) ? '0 : AW'(r_rp + AW'(1));
    assign full   = (r_count >= cap_eff);
    assign len    = i_in_item.read_length;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cfg_wr     = psel && penable && pwrite;
    assign mem_we     = in_xfer && (i_in_item.cmd == CMD_WRITE);

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_count     = r_count;
        n_primed    = r_primed;
        n_ovf       = r_ovf;
        n_underruns = r_underruns;
        n_overruns  = r_overruns;
        n_cap_raw   = r_cap_raw;
        n_prime     = r_prime;
        n_zero      = r_zero;
        n_left      = r_left;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;

        if (in_xfer) begin
            if (i_in_item.cmd == CMD_WRITE) begin
                n_wp = wp_inc;
                if (full) begin
                    // oldest byte overwritten, tail moves with the head
                    n_ovf = 1'b1;
                    n_rp  = wp_inc;
                end else begin
                    n_count = r_count + CFG_W'(1);
                end
                if (i_in_item.write_last) begin
                    if (r_ovf || full) begin
                        n_overruns = r_overruns + 32'd1;
                    end
                    n_ovf = 1'b0;
                end
            end else if (len != '0) begin
                n_left  = (len > 7'(MAX_READ)) ? 7'(MAX_READ) : len;
                n_state = ST_BURST;
                if (!r_primed && (r_count < thr)) begin
                    n_zero = 1'b1;
                end else begin
                    n_zero   = 1'b0;
                    n_primed = 1'b1;
                end
            end
        end

        if ((r_state == ST_BURST) && out_free) begin
            n_out_valid         = 1'b1;
            n_out_item.out_byte = 8'd0;
            if (!r_zero && (r_count != '0)) begin
                n_out_item.out_byte = rd_data;
                n_count             = r_count - CFG_W'(1);
                n_rp                = rp_inc;
            end else if (!r_zero && r_primed) begin
                // first padding byte of a short read
                n_primed    = 1'b0;
                n_underruns = r_underruns + 32'd1;
            end
            n_out_item.last           = (r_left == 7'd1);
            n_out_item.fill_level     = n_count;
            n_out_item.primed_flag    = n_primed;
            n_out_item.underrun_count = n_underruns;
            n_out_item.overrun_count  = n_overruns;
            n_left                    = r_left - 7'd1;
            if (r_left == 7'd1) begin
                n_state = ST_IDLE;
            end
        end

        if (cfg_wr) begin
            case (paddr[2])
                REG_CAPACITY: begin
                    n_cap_raw = pwdata[CFG_W-1:0];
                    n_wp      = '0;
                    n_rp      = '0;
                    n_count   = '0;
                    n_primed  = 1'b0;
                    n_ovf     = 1'b0;
                end
                REG_PRIME: begin
                    n_prime = pwdata[CFG_W-1:0];
                end
                default: begin
                    n_prime = r_prime;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_primed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_underruns <= '0;
            r_overruns  <= '0;
            r_cap_raw   <= CAPACITY_RST;
            r_prime     <= PRIME_RST;
            r_zero      <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_count     <= n_count;
            r_primed    <= n_primed;
            r_ovf       <= n_ovf;
            r_underruns <= n_underruns;
            r_overruns  <= n_overruns;
            r_cap_raw   <= n_cap_raw;
            r_prime     <= n_prime;
            r_zero      <= n_zero;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_out_item <= n_out_item;
    end

    // read port follows the next tail so the byte is ready when it is due
    porf_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_wp),
        .i_wdata(i_in_item.data_byte),
        .i_raddr(n_rp),
        .o_rdata(rd_data)
    );

    always_comb begin
        case (paddr[2])
            REG_CAPACITY: prdata = 32'(r_cap_raw);
            REG_PRIME:    prdata = 32'(r_prime);
            default:      prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/core/porf_ram.sv
// porf_ram: byte ring storage, one write port and one registered read port
// a write to the address being read in the same cycle is forwarded
// no dependencies
module porf_ram #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
